### rtl/nmp_pkg.sv
// ----------------------------------------------------------------------------
// nmp_pkg: shared types and constants for the node match probability block
// Defaults for the parameters and the controller to datapath command/status.
// ----------------------------------------------------------------------------
package nmp_pkg;
    localparam int DEGREE_BINS_DEF = 256;
    localparam int LABEL_BINS_DEF  = 256;
    localparam int COUNT_BITS_DEF  = 16;
    localparam int FIELD_BITS      = 8;
    localparam int PROB_BITS       = 33;
    localparam int FRAC_BITS       = 32;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_QUERY = 1'b1
    } t_opcode;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture request fields
        logic clr_step;  // clearing pass: write zero at sweep address
        logic add_rd;    // add: read bins
        logic add_wr;    // add: write incremented bins
        logic sum_start; // query: start tail sweep
        logic sum_step;  // query: accumulate one bin
        logic mul_step;  // query: one product stage
        logic div_init;  // query: load divider
        logic div_step;  // query: one quotient bit
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_done;
        logic sum_done;
        logic mul_done;
        logic div_done;
        logic full;
        logic empty;
    } t_stat;
endpackage

### rtl/node_match_probability.sv
// ----------------------------------------------------------------------------
// node_match_probability: selectivity estimator for subgraph matching
// Node histograms and a Q1.32 match probability for pattern-node queries.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_axis_*: one request per handshake. opcode in tuser
//   (0 add node, 1 query); tdata carries out_degree, in_degree, node_label.
//   Master channel m_axis_*: exactly one result per request, in order.
//   tdata holds probability (33 bits); tuser holds no_nodes, add_refused.
// Sequence:
//   Add: read bin, write bin, present result.
//   Query: label read, one bin a cycle through both degree histograms in
//   parallel plus pipeline drain, the product steps, then a 32-step
//   restoring divider, one quotient bit a cycle.
//   Empty-graph queries and refused adds go straight to the result.
// Throughput: one request in flight; the next is taken after the result
//   is handed over.
// Reset: a clearing pass writes zero to every bin; no request is taken
//   meanwhile.
// Stall: a result waits in the output register while m_axis_tready is low.
// ----------------------------------------------------------------------------
module node_match_probability #(
    parameter int DEGREE_BINS = nmp_pkg::DEGREE_BINS_DEF,
    parameter int LABEL_BINS  = nmp_pkg::LABEL_BINS_DEF,
    parameter int COUNT_BITS  = nmp_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // [7:0] out_degree, [15:8] in_degree, [23:16] node_label
    input  logic        s_axis_tuser,  // [0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // [32:0] probability, zero fill above
    output logic [1:0]  m_axis_tuser   // [0] no_nodes, [1] add_refused
);
    import nmp_pkg::*;

    t_cmd        w_cmd;
    t_stat       w_stat;
    logic [32:0] w_prob;
    logic        w_no_nodes, w_add_refused, w_zero;

    nmp_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .i_opcode(s_axis_tuser),
        .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_no_nodes(w_no_nodes), .o_add_refused(w_add_refused), .o_zero_prob(w_zero),
        .o_cmd(w_cmd), .i_stat(w_stat)
    );

    nmp_datapath #(
        .DEGREE_BINS(DEGREE_BINS), .LABEL_BINS(LABEL_BINS), .COUNT_BITS(COUNT_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd),
        .i_out_degree(s_axis_tdata[7:0]), .i_in_degree(s_axis_tdata[15:8]),
        .i_node_label(s_axis_tdata[23:16]),
        .o_stat(w_stat), .o_probability(w_prob)
    );

    // adds and empty queries report zero regardless of divider contents
    assign m_axis_tdata = {7'd0, w_zero ? 33'd0 : w_prob};
    assign m_axis_tuser = {w_add_refused, w_no_nodes};

    // no request is taken while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("ready during result");
    // refused add and no-nodes flags never together
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1])) else $error("both flags");
    // a flagged result always carries zero probability
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != 2'b00)) |-> (m_axis_tdata == 40'd0))
        else $error("flagged result nonzero");
endmodule

### rtl/nmp_ram.sv
// ----------------------------------------------------------------------------
// nmp_ram: generic single-port RAM
// One address a cycle: an optional write and a read of the old word, registered read data.
// ----------------------------------------------------------------------------
module nmp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

### rtl/nmp_datapath.sv
// ----------------------------------------------------------------------------
// nmp_datapath: histograms, tail sums, product and divider
// Three histogram RAMs, sweep counter, sequential multiply and restoring divide.
// ----------------------------------------------------------------------------
module nmp_datapath #(
    parameter int DEGREE_BINS = 256,
    parameter int LABEL_BINS  = 256,
    parameter int COUNT_BITS  = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  nmp_pkg::t_cmd            i_cmd,
    input  logic [7:0]               i_out_degree,
    input  logic [7:0]               i_in_degree,
    input  logic [7:0]               i_node_label,
    output nmp_pkg::t_stat           o_stat,
    output logic [32:0]              o_probability
);
    import nmp_pkg::*;

    localparam int DA = $clog2(DEGREE_BINS);
    localparam int LA = $clog2(LABEL_BINS);
    localparam int SA = (DA > LA) ? DA : LA;
    localparam int NB = 3 * COUNT_BITS;
    localparam int RB = NB + 1;
    localparam logic [COUNT_BITS-1:0] LIMIT = {COUNT_BITS{1'b1}};

    // request fields, saturated or range-checked
    logic [DA-1:0] r_od, r_id;
    logic [LA-1:0] r_lb;
    logic          r_od_over, r_id_over, r_lb_over;
    logic [COUNT_BITS-1:0] r_n;

    logic          n_od_over, n_id_over, n_lb_over;
    logic [DA-1:0] n_od_sat, n_id_sat;
    logic [LA-1:0] n_lb_sat;

    always_comb begin
        n_od_over = 32'(i_out_degree) > DEGREE_BINS - 1;
        n_id_over = 32'(i_in_degree)  > DEGREE_BINS - 1;
        n_lb_over = 32'(i_node_label) > LABEL_BINS - 1;
        n_od_sat  = n_od_over ? DA'(DEGREE_BINS - 1) : DA'(i_out_degree);
        n_id_sat  = n_id_over ? DA'(DEGREE_BINS - 1) : DA'(i_in_degree);
        n_lb_sat  = n_lb_over ? LA'(LABEL_BINS - 1)  : LA'(i_node_label);
    end

    // sweep counter, used by the clearing pass and the tail sums
    logic [SA:0] r_sw;
    logic [COUNT_BITS-1:0] r_a, r_b, r_c;

    logic [COUNT_BITS-1:0] w_od_q, w_id_q, w_lb_q;
    logic [DA-1:0] w_od_addr, w_id_addr;
    logic [LA-1:0] w_lb_addr;
    logic w_we;
    logic [COUNT_BITS-1:0] w_od_wd, w_id_wd, w_lb_wd;

    always_comb begin
        w_we      = i_cmd.clr_step | i_cmd.add_wr;
        w_od_addr = i_cmd.clr_step ? DA'(r_sw) : (i_cmd.sum_step ? DA'(r_sw) : r_od);
        w_id_addr = i_cmd.clr_step ? DA'(r_sw) : (i_cmd.sum_step ? DA'(r_sw) : r_id);
        w_lb_addr = i_cmd.clr_step ? LA'(r_sw) : r_lb;
        w_od_wd   = i_cmd.clr_step ? '0 : w_od_q + 1'b1;
        w_id_wd   = i_cmd.clr_step ? '0 : w_id_q + 1'b1;
        w_lb_wd   = i_cmd.clr_step ? '0 : w_lb_q + 1'b1;
    end

    nmp_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEGREE_BINS)) u_od_ram (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_od_addr), .i_wdata(w_od_wd), .o_rdata(w_od_q));
    nmp_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEGREE_BINS)) u_id_ram (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_id_addr), .i_wdata(w_id_wd), .o_rdata(w_id_q));
    nmp_ram #(.WIDTH(COUNT_BITS), .DEPTH(LABEL_BINS)) u_lb_ram (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_lb_addr), .i_wdata(w_lb_wd), .o_rdata(w_lb_q));

    // sum sweep: address r_sw issued each step, its data arrives in the cycle after
    logic [SA:0] r_rd_idx;
    logic        r_rd_vld;

    // products and divider
    logic [NB-1:0] r_num, r_den;
    logic [1:0]    r_mstep;
    logic [RB-1:0] r_rem;
    logic [32:0]   r_q;
    logic [5:0]    r_dcnt;

    logic [RB-1:0] w_sh, w_diff;

    assign w_sh   = {r_rem[RB-2:0], 1'b0};
    assign w_diff = w_sh - RB'(r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw  <= '0;
            r_n   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.sum_step && (32'(r_sw) < DEGREE_BINS);
            r_rd_idx <= r_sw;
            if (i_cmd.clr_step) begin
                r_sw <= r_sw + 1'b1;
            end else if (i_cmd.sum_start || i_cmd.load) begin
                r_sw <= '0;
            end else if (i_cmd.sum_step) begin
                r_sw <= r_sw + 1'b1;
            end
            if (i_cmd.add_wr) begin
                r_n <= r_n + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_od      <= n_od_sat;
            r_id      <= n_id_sat;
            r_lb      <= n_lb_sat;
            r_od_over <= n_od_over;
            r_id_over <= n_id_over;
            r_lb_over <= n_lb_over;
        end
        if (i_cmd.sum_start) begin
            r_a <= '0;
            r_b <= '0;
            r_c <= r_lb_over ? '0 : w_lb_q;
            r_mstep <= '0;
        end
        if (r_rd_vld) begin
            if (!r_od_over && DA'(r_rd_idx) >= r_od) r_a <= r_a + w_od_q;
            if (!r_id_over && DA'(r_rd_idx) >= r_id) r_b <= r_b + w_id_q;
        end
        if (i_cmd.mul_step) begin
            r_mstep <= r_mstep + 1'b1;
            unique case (r_mstep)
                2'd0: begin
                    r_num <= NB'(r_a * r_b);
                    r_den <= NB'(r_n * r_n);
                end
                2'd1: begin
                    r_num <= NB'(r_num[2*COUNT_BITS-1:0] * r_c);
                end
                2'd2: begin
                    r_den <= NB'(r_den[2*COUNT_BITS-1:0] * r_n);
                end
                default: ;
            endcase
        end
        if (i_cmd.div_init) begin
            r_rem  <= (RB'(r_num) >= RB'(r_den)) ? RB'(r_num) - RB'(r_den) : RB'(r_num);
            r_q    <= {32'd0, RB'(r_num) >= RB'(r_den)};
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt + 1'b1;
            if (w_sh >= RB'(r_den)) begin
                r_rem <= w_diff;
                r_q   <= {r_q[31:0], 1'b1};
            end else begin
                r_rem <= w_sh;
                r_q   <= {r_q[31:0], 1'b0};
            end
        end
    end

    assign o_stat.clr_done = (r_sw == (SA+1)'(2**SA - 1));
    assign o_stat.sum_done = (32'(r_sw) >= DEGREE_BINS + 1);
    assign o_stat.mul_done = (r_mstep == 2'd3);
    assign o_stat.div_done = (r_dcnt == 6'(FRAC_BITS));
    assign o_stat.full     = (r_n == LIMIT);
    assign o_stat.empty    = (r_n == '0);
    assign o_probability   = r_q;
endmodule

### rtl/nmp_ctrl.sv
// ----------------------------------------------------------------------------
// nmp_ctrl: sequencer for the node match probability block
// Clearing pass, add read-modify-write, query sweep, multiply and divide.
// ----------------------------------------------------------------------------
module nmp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_opcode,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic           o_no_nodes,
    output logic           o_add_refused,
    output logic           o_zero_prob,
    output nmp_pkg::t_cmd  o_cmd,
    input  nmp_pkg::t_stat i_stat
);
    import nmp_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ADD_RD, S_ADD_WR, S_Q_LBL, S_SUM, S_MUL, S_DIV0, S_DIV, S_OUT
    } t_state;

    t_state r_state;
    logic   r_no_nodes, r_add_refused, r_zero_prob;

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = (r_state == S_OUT);
    assign o_no_nodes    = r_no_nodes;
    assign o_add_refused = r_add_refused;
    assign o_zero_prob   = r_zero_prob;

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_CLEAR:  o_cmd.clr_step  = 1'b1;
            S_IDLE:   o_cmd.load      = i_in_valid;
            S_ADD_RD: o_cmd.add_rd    = 1'b1;
            S_ADD_WR: o_cmd.add_wr    = 1'b1;
            S_Q_LBL:  o_cmd.sum_start = 1'b1;
            S_SUM:    o_cmd.sum_step  = 1'b1;
            S_MUL:    o_cmd.mul_step  = 1'b1;
            S_DIV0:   o_cmd.div_init  = 1'b1;
            S_DIV:    o_cmd.div_step  = !i_stat.div_done;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_no_nodes    <= 1'b0;
            r_add_refused <= 1'b0;
            r_zero_prob   <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: if (i_stat.clr_done) r_state <= S_IDLE;
                S_IDLE: if (i_in_valid) begin
                    r_no_nodes    <= 1'b0;
                    r_add_refused <= 1'b0;
                    r_zero_prob   <= 1'b0;
                    if (i_opcode == OP_ADD) begin
                        if (i_stat.full) begin
                            r_add_refused <= 1'b1;
                            r_zero_prob   <= 1'b1;
                            r_state       <= S_OUT;
                        end else begin
                            r_zero_prob <= 1'b1;
                            r_state     <= S_ADD_RD;
                        end
                    end else if (i_stat.empty) begin
                        r_no_nodes  <= 1'b1;
                        r_zero_prob <= 1'b1;
                        r_state     <= S_OUT;
                    end else begin
                        r_state <= S_ADD_RD;
                    end
                end
                S_ADD_RD: r_state <= r_zero_prob ? S_ADD_WR : S_Q_LBL;
                S_ADD_WR: r_state <= S_OUT;
                S_Q_LBL:  r_state <= S_SUM;
                S_SUM:    if (i_stat.sum_done) r_state <= S_MUL;
                S_MUL:    if (i_stat.mul_done) r_state <= S_DIV0;
                S_DIV0:   r_state <= S_DIV;
                S_DIV:    if (i_stat.div_done) r_state <= S_OUT;
                S_OUT:    if (i_out_ready) r_state <= S_IDLE;
                default:  r_state <= S_IDLE;
            endcase
        end
    end
endmodule
